FILE: hw/rtl/psq_pkg.sv
// Shared types, constants and helpers for the priority sorted queue.
// Depends on nothing; every other file but psq_ram imports it.
`default_nettype none

package psq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ID_W    = 16;
    localparam int AGE_W   = 7;
    localparam int SEV_W   = 4;
    localparam int SCORE_W = 10;

    localparam int SEV_CLASSES = 1 << SEV_W;

    localparam logic [AGE_W-1:0]   AGE_MAX    = 7'd120;
    localparam logic [SEV_W-1:0]   SEV_MIN    = 4'd1;
    localparam logic [SEV_W-1:0]   SEV_MAX    = 4'd10;
    localparam logic [SCORE_W-1:0] SEV_WEIGHT = 10'd50;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0]  CFG_CRITICAL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_URGENT     = 1'b1;
    localparam logic [CFG_DATA_W-1:0] CRITICAL_RESET = 4'd8;
    localparam logic [CFG_DATA_W-1:0] URGENT_RESET   = 4'd4;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_INVALID   = 3'd4
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [AGE_W-1:0]   age;
        logic [SEV_W-1:0]   sev;
        logic [SCORE_W-1:0] score;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             inc;
        logic             dec;
        logic             start;
        logic [SEV_W-1:0] sev;
    } class_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] critical;
        logic [CNT_W-1:0] urgent;
        logic [CNT_W-1:0] minor;
    } class_totals_t;

    // Physical address of a queue position, counted from the head.
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [ADDR_W-1:0] offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (ADDR_W+1)'(CAPACITY)) begin
            sum = sum - (ADDR_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/psq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module psq_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/psq_class_count.sv
// Per-severity histogram of queued entries and a sequential tally of the
// critical, urgent and minor totals. Depends on psq_pkg.
`default_nettype none

module psq_class_count (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire psq_pkg::class_ctl_t               ctl,
    input  wire logic [psq_pkg::CFG_DATA_W-1:0]    critical_level,
    input  wire logic [psq_pkg::CFG_DATA_W-1:0]    urgent_level,
    output      psq_pkg::class_totals_t            totals,
    output      logic                              done
);
    import psq_pkg::*;

    logic [CNT_W-1:0] hist_reg [SEV_CLASSES];
    logic [CNT_W-1:0] hist_next [SEV_CLASSES];
    logic [SEV_W-1:0] tidx_reg, tidx_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    class_totals_t    acc_reg, acc_next;
    logic [CNT_W-1:0] bin;

    always_comb begin
        for (int s = 0; s < SEV_CLASSES; s++) begin
            hist_next[s] = hist_reg[s];
            if (ctl.inc && (ctl.sev == SEV_W'(s))) begin
                hist_next[s] = hist_reg[s] + CNT_W'(1);
            end else if (ctl.dec && (ctl.sev == SEV_W'(s))) begin
                hist_next[s] = hist_reg[s] - CNT_W'(1);
            end
        end
    end

    assign bin = hist_reg[tidx_reg];

    always_comb begin
        tidx_next = tidx_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        if (ctl.start) begin
            tidx_next = '0;
            busy_next = 1'b1;
            acc_next  = '0;
        end else if (busy_reg) begin
            // Class bounds are compared as written, so odd levels behave as given.
            if (tidx_reg >= critical_level) begin
                acc_next.critical = acc_reg.critical + bin;
            end else if (tidx_reg >= urgent_level) begin
                acc_next.urgent = acc_reg.urgent + bin;
            end else begin
                acc_next.minor = acc_reg.minor + bin;
            end
            tidx_next = tidx_reg + SEV_W'(1);
            if (tidx_reg == SEV_W'(SEV_CLASSES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < SEV_CLASSES; s++) begin
                hist_reg[s] <= '0;
            end
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            hist_reg <= hist_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        tidx_reg <= tidx_next;
        acc_reg  <= acc_next;
    end

    assign totals = acc_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/priority_sorted_queue.sv
// Top level of the priority sorted queue: request sequencer, entry memory
// and class counter. Depends on psq_pkg, psq_ram and psq_class_count.
`default_nettype none

// The queue holds up to CAPACITY entries (64) sorted by score, where the score
// is severity*50+age in units of 0.2. An insert lands behind every entry of an
// equal or higher score, so equal scores leave first in, first out. Entries
// live in one simple dual-port RAM used as a ring: a pop only moves the head
// pointer, while an insert walks from the head to find its place and then
// moves the entries behind it up by one slot. One request is in work at a
// time; s_ready is high while the sequencer is idle, and a finished result is
// held in the output register, so the next request can be taken while the
// previous result still waits on m_ready. From acceptance to the result being
// offered: a pop reads the head entry; a search scans from the head until a
// hit or the end of the fill count (an empty queue ends the scan at once); an
// insert scans for its place, then moves the entries behind it and writes the
// new entry, or at the tail only writes it; a rejected request goes straight
// to the tally. Every transaction ends with the tally of the sixteen severity
// bins into the three class totals and then the output state. Both the scan
// and the move issue one RAM read per cycle. The memory needs no clearing
// after reset, because only slots inside the fill count are ever read. The
// class levels may be written through the cfg port while no transaction is in
// work.

module priority_sorted_queue (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire logic [1:0]                     s_req_type,
    input  wire logic [psq_pkg::AGE_W-1:0]      s_age_in,
    input  wire logic [psq_pkg::SEV_W-1:0]      s_severity_in,
    input  wire logic [psq_pkg::ID_W-1:0]       s_search_key,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic [2:0]                     m_status,
    output      logic [15:0]                    m_entry_id,
    output      logic [6:0]                     m_entry_age,
    output      logic [3:0]                     m_entry_severity,
    output      logic [9:0]                     m_entry_score,
    output      logic [5:0]                     m_position,
    output      logic [6:0]                     m_fill_level,
    output      logic [6:0]                     m_critical_total,
    output      logic [6:0]                     m_urgent_total,
    output      logic [6:0]                     m_minor_total,
    input  wire logic                           cfg_we,
    input  wire logic [psq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import psq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_SHIFT    = 7'b0000100,
        S_POP_RD   = 7'b0001000,
        S_POP_DATA = 7'b0010000,
        S_TALLY    = 7'b0100000,
        S_OUT      = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;

    // Queue bookkeeping.
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ID_W-1:0]       next_id_reg, next_id_next;
    logic [CFG_DATA_W-1:0] critical_reg, critical_next;
    logic [CFG_DATA_W-1:0] urgent_reg, urgent_next;

    // Transaction in work.
    logic                  op_insert_reg, op_insert_next;
    logic [ID_W-1:0]       key_reg, key_next;
    status_t               res_status_reg, res_status_next;
    entry_t                res_entry_reg, res_entry_next;
    logic [ADDR_W-1:0]     res_pos_reg, res_pos_next;

    // Walk pointer and the read that is in flight in the RAM.
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [ADDR_W-1:0]     pend_idx_reg, pend_idx_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            m_status_reg, m_status_next;
    entry_t                m_entry_reg, m_entry_next;
    logic [5:0]            m_position_reg, m_position_next;
    logic [6:0]            m_fill_reg, m_fill_next;
    logic [6:0]            m_crit_reg, m_crit_next;
    logic [6:0]            m_urg_reg, m_urg_next;
    logic [6:0]            m_minor_reg, m_minor_next;

    // RAM port signals.
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    entry_t                ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    class_ctl_t            cls_ctl;
    class_totals_t         cls_totals;
    logic                  cls_done;

    logic                  scan_issue;
    logic                  scan_hit;
    logic                  shift_issue;
    logic [SCORE_W-1:0]    new_score;
    logic                  insert_bad;

    psq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_entry_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    psq_class_count u_class_count (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (cls_ctl),
        .critical_level(critical_reg),
        .urgent_level  (urgent_reg),
        .totals        (cls_totals),
        .done          (cls_done)
    );

    assign rd_entry = entry_t'(ram_rdata);

    assign new_score  = SCORE_W'(s_severity_in) * SEV_WEIGHT + SCORE_W'(s_age_in);
    assign insert_bad = (s_age_in > AGE_MAX) || (s_severity_in < SEV_MIN) ||
                        (s_severity_in > SEV_MAX);

    // An insert stops at the first entry with a strictly lower score; a search
    // stops at the first matching id, which is the one nearest the head.
    assign scan_hit = pend_vld_reg &&
                      (op_insert_reg ? (rd_entry.score < res_entry_reg.score)
                                     : (rd_entry.id == key_reg));
    assign scan_issue  = (idx_reg < count_reg);
    assign shift_issue = (idx_reg > CNT_W'(res_pos_reg));

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        critical_next   = critical_reg;
        urgent_next     = urgent_reg;
        op_insert_next  = op_insert_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_pos_next    = res_pos_reg;
        idx_next        = idx_reg;
        pend_vld_next   = 1'b0;
        pend_idx_next   = pend_idx_reg;

        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_entry_next    = m_entry_reg;
        m_position_next = m_position_reg;
        m_fill_next     = m_fill_reg;
        m_crit_next     = m_crit_reg;
        m_urg_next      = m_urg_reg;
        m_minor_next    = m_minor_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = rd_entry;
        ram_re    = 1'b0;
        ram_raddr = head_reg;

        cls_ctl       = '0;
        cls_ctl.sev   = res_entry_reg.sev;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_index)
                CFG_CRITICAL: critical_next = cfg_wdata;
                CFG_URGENT:   urgent_next   = cfg_wdata;
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_status_next = ST_OK;
                    res_entry_next  = '0;
                    res_pos_next    = '0;
                    key_next        = s_search_key;
                    idx_next        = '0;
                    op_insert_next  = 1'b0;
                    case (s_req_type)
                        REQ_INSERT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                                state_next      = S_TALLY;
                            end else if (insert_bad) begin
                                res_status_next = ST_INVALID;
                                state_next      = S_TALLY;
                            end else begin
                                op_insert_next       = 1'b1;
                                res_entry_next.id    = next_id_reg;
                                res_entry_next.age   = s_age_in;
                                res_entry_next.sev   = s_severity_in;
                                res_entry_next.score = new_score;
                                next_id_next         = next_id_reg + ID_W'(1);
                                state_next           = S_SCAN;
                            end
                        end
                        REQ_POP: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_TALLY;
                            end else begin
                                state_next = S_POP_RD;
                            end
                        end
                        REQ_SEARCH: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            res_status_next = ST_INVALID;
                            state_next      = S_TALLY;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // One read is issued per cycle while the one before it is compared.
                if (scan_issue) begin
                    ram_re        = 1'b1;
                    ram_raddr     = phys_addr(head_reg, ADDR_W'(idx_reg));
                    pend_vld_next = 1'b1;
                    pend_idx_next = ADDR_W'(idx_reg);
                    idx_next      = idx_reg + CNT_W'(1);
                end
                if (scan_hit) begin
                    pend_vld_next = 1'b0;
                    if (op_insert_reg) begin
                        res_pos_next = pend_idx_reg;
                        idx_next     = count_reg;
                        state_next   = S_SHIFT;
                    end else begin
                        res_entry_next = rd_entry;
                        res_pos_next   = pend_idx_reg;
                        state_next     = S_TALLY;
                    end
                end else if (!scan_issue && !pend_vld_reg) begin
                    if (op_insert_reg) begin
                        res_pos_next = ADDR_W'(count_reg);
                        idx_next     = count_reg;
                        state_next   = S_SHIFT;
                    end else begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_TALLY;
                    end
                end
            end

            S_SHIFT: begin
                // Move the tail up one slot, last entry first, then drop the
                // new entry into the opened slot.
                if (pend_vld_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys_addr(head_reg, pend_idx_reg + ADDR_W'(1));
                    ram_wdata = rd_entry;
                end
                if (shift_issue) begin
                    ram_re        = 1'b1;
                    ram_raddr     = phys_addr(head_reg, ADDR_W'(idx_reg - CNT_W'(1)));
                    pend_vld_next = 1'b1;
                    pend_idx_next = ADDR_W'(idx_reg - CNT_W'(1));
                    idx_next      = idx_reg - CNT_W'(1);
                end else if (!pend_vld_reg) begin
                    ram_we      = 1'b1;
                    ram_waddr   = phys_addr(head_reg, res_pos_reg);
                    ram_wdata   = res_entry_reg;
                    count_next  = count_reg + CNT_W'(1);
                    cls_ctl.inc = 1'b1;
                    cls_ctl.sev = res_entry_reg.sev;
                    state_next  = S_TALLY;
                end
            end

            S_POP_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = head_reg;
                state_next = S_POP_DATA;
            end

            S_POP_DATA: begin
                res_entry_next = rd_entry;
                res_pos_next   = '0;
                if (head_reg == ADDR_W'(CAPACITY - 1)) begin
                    head_next = '0;
                end else begin
                    head_next = head_reg + ADDR_W'(1);
                end
                count_next  = count_reg - CNT_W'(1);
                cls_ctl.dec = 1'b1;
                cls_ctl.sev = rd_entry.sev;
                state_next  = S_TALLY;
            end

            S_TALLY: begin
                if (cls_done) begin
                    state_next = S_OUT;
                end
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = res_status_reg;
                    m_fill_next     = 7'(count_reg);
                    m_crit_next     = 7'(cls_totals.critical);
                    m_urg_next      = 7'(cls_totals.urgent);
                    m_minor_next    = 7'(cls_totals.minor);
                    if (res_status_reg == ST_OK) begin
                        m_entry_next    = res_entry_reg;
                        m_position_next = 6'(res_pos_reg);
                    end else begin
                        m_entry_next    = '0;
                        m_position_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // The tally starts once the queue state of this transaction is final.
        if ((state_next == S_TALLY) && (state_reg != S_TALLY)) begin
            cls_ctl.start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            next_id_reg  <= ID_W'(1);
            critical_reg <= CRITICAL_RESET;
            urgent_reg   <= URGENT_RESET;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            critical_reg <= critical_next;
            urgent_reg   <= urgent_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        op_insert_reg  <= op_insert_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_pos_reg    <= res_pos_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        m_status_reg   <= m_status_next;
        m_entry_reg    <= m_entry_next;
        m_position_reg <= m_position_next;
        m_fill_reg     <= m_fill_next;
        m_crit_reg     <= m_crit_next;
        m_urg_reg      <= m_urg_next;
        m_minor_reg    <= m_minor_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_entry_id       = m_entry_reg.id;
    assign m_entry_age      = m_entry_reg.age;
    assign m_entry_severity = m_entry_reg.sev;
    assign m_entry_score    = m_entry_reg.score;
    assign m_position       = m_position_reg;
    assign m_fill_level     = m_fill_reg;
    assign m_critical_total = m_crit_reg;
    assign m_urgent_total   = m_urg_reg;
    assign m_minor_total    = m_minor_reg;

endmodule

`default_nettype wire

FILE: sim/psq_result_check.sv
// Result checker for the priority sorted queue: keeps its own copy of the sorted
// entries and class levels, predicts every result and compares it field by field.
// Depends on psq_pkg for widths, request codes, status codes and the entry layout.

module psq_result_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [psq_pkg::AGE_W-1:0]      s_age_in,
    input  logic [psq_pkg::SEV_W-1:0]      s_severity_in,
    input  logic [psq_pkg::ID_W-1:0]       s_search_key,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [2:0]                     m_status,
    input  logic [15:0]                    m_entry_id,
    input  logic [6:0]                     m_entry_age,
    input  logic [3:0]                     m_entry_severity,
    input  logic [9:0]                     m_entry_score,
    input  logic [5:0]                     m_position,
    input  logic [6:0]                     m_fill_level,
    input  logic [6:0]                     m_critical_total,
    input  logic [6:0]                     m_urgent_total,
    input  logic [6:0]                     m_minor_total,
    input  logic                           cfg_we,
    input  logic [psq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    // Beyond this many mismatches the rest are only counted.
    localparam int REPORT_CAP = 40;

    typedef struct {
        status_t      status;
        logic [15:0]  id;
        logic [6:0]   age;
        logic [3:0]   sev;
        logic [9:0]   score;
        logic [5:0]   pos;
        logic [6:0]   fill;
        logic [6:0]   crit;
        logic [6:0]   urg;
        logic [6:0]   minor;
    } outcome_t;

    entry_t              ranked_entries[$];
    outcome_t            outcomes_due[$];
    logic [ID_W-1:0]     id_counter;
    logic [SEV_W-1:0]    crit_level;
    logic [SEV_W-1:0]    urgent_level;
    int                  fails;

    // Applies one request to the entry list and returns the result it yields.
    function automatic outcome_t apply_request(input logic [1:0]       req,
                                               input logic [AGE_W-1:0] age,
                                               input logic [SEV_W-1:0] sev,
                                               input logic [ID_W-1:0]  key);
        outcome_t r;
        entry_t   e;
        int       slot;
        r.status = ST_OK;
        r.id     = '0;
        r.age    = '0;
        r.sev    = '0;
        r.score  = '0;
        r.pos    = '0;
        r.crit   = '0;
        r.urg    = '0;
        r.minor  = '0;
        e        = '0;
        slot     = 0;
        case (req)
            REQ_INSERT: begin
                // A full queue is reported before the fields are looked at.
                if (ranked_entries.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (age > AGE_MAX || sev < SEV_MIN || sev > SEV_MAX) begin
                    r.status = ST_INVALID;
                end else begin
                    e.id       = id_counter;
                    e.age      = age;
                    e.sev      = sev;
                    e.score    = SCORE_W'(sev) * SEV_WEIGHT + SCORE_W'(age);
                    id_counter = id_counter + 1'b1;
                    // The new entry goes behind every entry of equal or higher score.
                    slot = ranked_entries.size();
                    for (int i = 0; i < ranked_entries.size(); i++) begin
                        if (ranked_entries[i].score < e.score) begin
                            slot = i;
                            break;
                        end
                    end
                    ranked_entries.insert(slot, e);
                end
            end
            REQ_POP: begin
                if (ranked_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = ranked_entries.pop_front();
                end
            end
            REQ_SEARCH: begin
                slot = -1;
                for (int i = 0; i < ranked_entries.size(); i++) begin
                    if (ranked_entries[i].id == key) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    e = ranked_entries[slot];
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        if (r.status == ST_OK) begin
            r.id    = e.id;
            r.age   = e.age;
            r.sev   = e.sev;
            r.score = e.score;
            r.pos   = slot[5:0];
        end
        foreach (ranked_entries[i]) begin
            if (ranked_entries[i].sev >= crit_level) begin
                r.crit++;
            end else if (ranked_entries[i].sev >= urgent_level) begin
                r.urg++;
            end else begin
                r.minor++;
            end
        end
        r.fill = 7'(ranked_entries.size());
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_CAP) begin
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            ranked_entries.delete();
            outcomes_due.delete();
            id_counter   = 16'd1;
            crit_level   = CRITICAL_RESET;
            urgent_level = URGENT_RESET;
        end else begin
            // Results first; a result never arrives in the cycle its request is taken.
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_CAP) begin
                        $error("result transaction with no request outstanding");
                    end
                end else begin
                    want = outcomes_due.pop_front();
                    compare_field("status", 16'(want.status), 16'(m_status));
                    compare_field("entry_id", want.id, m_entry_id);
                    compare_field("entry_age", 16'(want.age), 16'(m_entry_age));
                    compare_field("entry_severity", 16'(want.sev), 16'(m_entry_severity));
                    compare_field("entry_score", 16'(want.score), 16'(m_entry_score));
                    compare_field("position", 16'(want.pos), 16'(m_position));
                    compare_field("fill_level", 16'(want.fill), 16'(m_fill_level));
                    compare_field("critical_total", 16'(want.crit), 16'(m_critical_total));
                    compare_field("urgent_total", 16'(want.urg), 16'(m_urgent_total));
                    compare_field("minor_total", 16'(want.minor), 16'(m_minor_total));
                end
            end
            if (s_valid && s_ready) begin
                outcomes_due.push_back(apply_request(s_req_type, s_age_in,
                                                     s_severity_in, s_search_key));
            end
            if (cfg_we) begin
                if (cfg_index == CFG_CRITICAL) begin
                    crit_level = cfg_wdata;
                end else if (cfg_index == CFG_URGENT) begin
                    urgent_level = cfg_wdata;
                end
            end
        end
        fail_count  <= fails;
        results_due <= outcomes_due.size();
    end

endmodule

FILE: sim/priority_sorted_queue_tb.sv
// Top of the priority sorted queue testbench: clock, reset, request stimulus,
// configuration writes and the final verdict. Depends on psq_pkg, the block
// priority_sorted_queue and the result checker psq_result_check.

module priority_sorted_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    // About 1600 transactions, each with its block work, a random sender gap and
    // random receiver stalls, take far fewer cycles than this limit, which leaves
    // a wide margin.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    // Request code that the block does not define; it must come back as invalid.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int AGE_TOP  = (1 << AGE_W) - 1;
    localparam int SEV_TOP  = (1 << SEV_W) - 1;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } burst_kind_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type    = '0;
    logic [AGE_W-1:0]      s_age_in      = '0;
    logic [SEV_W-1:0]      s_severity_in = '0;
    logic [ID_W-1:0]       s_search_key  = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [2:0]            m_status;
    logic [15:0]           m_entry_id;
    logic [6:0]            m_entry_age;
    logic [3:0]            m_entry_severity;
    logic [9:0]            m_entry_score;
    logic [5:0]            m_position;
    logic [6:0]            m_fill_level;
    logic [6:0]            m_critical_total;
    logic [6:0]            m_urgent_total;
    logic [6:0]            m_minor_total;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    int                    fail_count;
    int                    results_due;
    int                    stall_pct     = 0;
    int unsigned           cycle_count   = 0;
    logic [ID_W-1:0]       last_ok_id    = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    priority_sorted_queue uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_age_in         (s_age_in),
        .s_severity_in    (s_severity_in),
        .s_search_key     (s_search_key),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_id       (m_entry_id),
        .m_entry_age      (m_entry_age),
        .m_entry_severity (m_entry_severity),
        .m_entry_score    (m_entry_score),
        .m_position       (m_position),
        .m_fill_level     (m_fill_level),
        .m_critical_total (m_critical_total),
        .m_urgent_total   (m_urgent_total),
        .m_minor_total    (m_minor_total),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    psq_result_check result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_age_in         (s_age_in),
        .s_severity_in    (s_severity_in),
        .s_search_key     (s_search_key),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_id       (m_entry_id),
        .m_entry_age      (m_entry_age),
        .m_entry_severity (m_entry_severity),
        .m_entry_score    (m_entry_score),
        .m_position       (m_position),
        .m_fill_level     (m_fill_level),
        .m_critical_total (m_critical_total),
        .m_urgent_total   (m_urgent_total),
        .m_minor_total    (m_minor_total),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .results_due      (results_due)
    );

    // The receiver drops ready on a random share of cycles set by stall_pct.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Remember the id of the latest successful result, so that searches can aim
    // at ids that are likely still queued.
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_status == ST_OK) begin
            last_ok_id <= m_entry_id;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Presents one request and returns at the edge where it is accepted. Valid
    // stays high on return, so a back-to-back request needs no extra edge.
    task automatic send_request(input logic [1:0]       req,
                                input logic [AGE_W-1:0] age,
                                input logic [SEV_W-1:0] sev,
                                input logic [ID_W-1:0]  key);
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_age_in      <= age;
        s_severity_in <= sev;
        s_search_key  <= key;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Lowers valid and waits until every predicted result has been taken.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (results_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both class levels; the block must be idle when this is called.
    task automatic set_levels(input logic [CFG_DATA_W-1:0] crit,
                              input logic [CFG_DATA_W-1:0] urg);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CRITICAL;
        cfg_wdata <= crit;
        @(posedge aclk);
        cfg_index <= CFG_URGENT;
        cfg_wdata <= urg;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One random request, shaped by the kind of burst it belongs to. Fill bursts
    // push the queue toward full, drain bursts toward empty, mixed bursts wander.
    task automatic send_random(input burst_kind_t kind, input int idle_pct);
        int               roll;
        int               insert_pct;
        int               pop_pct;
        logic [1:0]       req;
        logic [AGE_W-1:0] age;
        logic [SEV_W-1:0] sev;
        logic [ID_W-1:0]  key;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            // Mostly short gaps, sometimes long enough for the block to go idle.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 160)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
        case (kind)
            BURST_FILL: begin
                insert_pct = 85;
                pop_pct    = 5;
            end
            BURST_DRAIN: begin
                insert_pct = 15;
                pop_pct    = 70;
            end
            default: begin
                insert_pct = 40;
                pop_pct    = 30;
            end
        endcase
        // Unused fields carry random noise on every request.
        age  = AGE_W'($urandom_range(0, AGE_TOP));
        sev  = SEV_W'($urandom_range(0, SEV_TOP));
        key  = ID_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            req = REQ_UNUSED;
        end else if (roll < 3 + insert_pct) begin
            req  = REQ_INSERT;
            age  = AGE_W'($urandom_range(0, AGE_MAX));
            sev  = SEV_W'($urandom_range(SEV_MIN, SEV_MAX));
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                age = AGE_W'($urandom_range(AGE_MAX + 1, AGE_TOP));
            end else if (roll < 5) begin
                sev = '0;
            end else if (roll < 8) begin
                sev = SEV_W'($urandom_range(SEV_MAX + 1, SEV_TOP));
            end else if (roll < 33) begin
                // A narrow grid of scores so that equal scores are common.
                age = AGE_W'(10 * $urandom_range(0, 5));
                sev = SEV_W'($urandom_range(SEV_MIN, 3));
            end
        end else if (roll < 3 + insert_pct + pop_pct) begin
            req = REQ_POP;
        end else begin
            req  = REQ_SEARCH;
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                key = last_ok_id - ID_W'($urandom_range(0, 64));
            end else if (roll == 8) begin
                key = '0;
            end else if (roll == 9) begin
                key = '1;
            end
        end
        send_request(req, age, sev, key);
    endtask

    // A random phase under one idling profile and one pair of class levels. Half
    // way through, the sender holds off until the queue has answered everything.
    task automatic run_phase(input int items, input int send_idle, input int recv_stall,
                             input logic [CFG_DATA_W-1:0] crit,
                             input logic [CFG_DATA_W-1:0] urg);
        int          sent;
        int          burst_len;
        burst_kind_t kind;
        wait_idle();
        set_levels(crit, urg);
        stall_pct <= recv_stall;
        sent = 0;
        while (sent < items) begin
            kind      = burst_kind_t'($urandom_range(0, 2));
            burst_len = $urandom_range(10, 80);
            for (int k = 0; k < burst_len && sent < items; k++) begin
                if (sent == items / 2) begin
                    wait_idle();
                end
                send_random(kind, send_idle);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with the reset levels. Ids start at 1 after reset, so
        // the ids searched for below are known in advance.
        send_request(REQ_POP, '0, '0, '0);            // pop on an empty queue
        send_request(REQ_SEARCH, '0, '0, '0);         // search on an empty queue
        send_request(REQ_INSERT, '0, SEV_MIN, '0);    // lowest score, id 1
        send_request(REQ_INSERT, AGE_MAX, SEV_MAX, '0); // highest score, id 2
        send_request(REQ_INSERT, AGE_MAX + 1'b1, 4'd5, '0);
        send_request(REQ_INSERT, '1, '1, '1);
        send_request(REQ_INSERT, 7'd10, '0, '0);
        send_request(REQ_INSERT, 7'd10, SEV_MAX + 1'b1, '0);
        send_request(REQ_UNUSED, '1, '1, '1);
        // Two different inputs with the same score: the later one lands behind.
        send_request(REQ_INSERT, 7'd50, 4'd1, '0);
        send_request(REQ_INSERT, 7'd0, 4'd2, '0);
        // Severities on and just below the class boundaries.
        send_request(REQ_INSERT, 7'd0, URGENT_RESET, '0);
        send_request(REQ_INSERT, 7'd0, URGENT_RESET - 1'b1, '0);
        send_request(REQ_INSERT, 7'd0, CRITICAL_RESET, '0);
        send_request(REQ_INSERT, 7'd0, CRITICAL_RESET - 1'b1, '0);
        send_request(REQ_SEARCH, '0, '0, '1);         // miss on the largest key
        send_request(REQ_SEARCH, '0, '0, 16'd3);      // hit in the middle
        send_request(REQ_SEARCH, '0, '0, 16'd1);      // hit at the tail
        send_request(REQ_POP, '0, '0, '0);
        send_request(REQ_POP, '0, '0, '0);
        send_request(REQ_SEARCH, '0, '0, 16'd2);      // id already popped

        // Random phases: level extremes, including levels outside 1..10, under
        // each idling profile.
        run_phase(310, 0, 0, 4'd1, 4'd10);
        run_phase(310, 58, 0, 4'd10, 4'd1);
        run_phase(310, 0, 58, 4'd0, 4'd15);
        run_phase(310, 20, 20, 4'd15, 4'd0);
        run_phase(310, 0, 0, 4'd6, 4'd3);

        // Let every result come back, then watch a while for stray results.
        wait_idle();
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/psq_pkg.sv
hw/rtl/psq_ram.sv
hw/rtl/psq_class_count.sv
hw/rtl/priority_sorted_queue.sv
sim/psq_result_check.sv
sim/priority_sorted_queue_tb.sv
